FILE: design/ttf_pkg.sv
// Package for the triangle tangent frame block: field widths, the sequencer state type
// and the default fixed-point setting. Used by every module of the block.
`default_nettype none
package ttf_pkg;
    localparam int POS_W   = 32;          // corner position and result component width
    localparam int UV_W    = 16;          // texture coordinate width
    localparam int DUV_W   = UV_W + 1;    // texture coordinate difference
    localparam int EDGE_W  = POS_W + 1;   // position difference
    localparam int PROD_W  = DUV_W + EDGE_W;
    localparam int ACC_W   = PROD_W + 1;  // numerator after one subtract
    localparam int DET_W   = 2 * DUV_W + 1;
    localparam int NUM_COMP = 6;
    localparam int TERM_W  = 4;
    localparam int UV_FRAC_DEF = 14;
    localparam logic [TERM_W-1:0] TERM_DET_LAST = TERM_W'(1);
    localparam logic [TERM_W-1:0] TERM_FIRST_COMP = TERM_W'(2);
    localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(13);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT
    } t_state;
endpackage
`default_nettype wire

FILE: design/ttf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ttf_pkg for the operand widths.
`default_nettype none
module ttf_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [ttf_pkg::DUV_W-1:0]  i_a,
    input  wire logic signed [ttf_pkg::EDGE_W-1:0] i_b,
    output logic signed [ttf_pkg::PROD_W-1:0]      o_prod
);
    import ttf_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

FILE: design/ttf_div.sv
// Restoring divider, one quotient bit per cycle: (num * 2^UV_FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits. Depends on ttf_pkg.
`default_nettype none
module ttf_div #(
    parameter int UV_FRAC_BITS = ttf_pkg::UV_FRAC_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [ttf_pkg::ACC_W-1:0]  i_num,
    input  wire logic signed [ttf_pkg::DET_W-1:0]  i_den,
    output logic                                   o_done,
    output logic signed [ttf_pkg::POS_W-1:0]       o_quo
);
    import ttf_pkg::*;

    localparam int DW = ACC_W + UV_FRAC_BITS;
    localparam int QW = POS_W;

    logic [ACC_W-1:0] an;
    logic [DET_W-1:0] ad;
    logic [DW-1:0]    dwide;
    logic [DW-QW-1:0] dhi;
    logic [DET_W:0]   rem2;
    logic             ge;
    logic [QW-1:0]    lim;
    logic [QW-1:0]    mag;

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [DET_W-1:0] r_ad;
    logic [DET_W-1:0] r_rem;
    logic [QW-1:0]    r_dq;
    logic             r_neg;
    logic             r_ovf;

    assign an    = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign ad    = i_den[DET_W-1] ? DET_W'(-i_den) : DET_W'(i_den);
    assign dwide = {an, {UV_FRAC_BITS{1'b0}}};
    assign dhi   = dwide[DW-1:QW];
    assign rem2  = {r_rem, r_dq[QW-1]};
    assign ge    = rem2 >= {1'b0, r_ad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ad  <= ad;
            r_rem <= DET_W'(dhi);
            r_dq  <= dwide[QW-1:0];
            r_neg <= i_num[ACC_W-1] ^ i_den[DET_W-1];
            // A quotient of 2^32 or more saturates whatever the low bits give.
            r_ovf <= DET_W'(dhi) >= ad;
        end else if (r_busy) begin
            r_rem <= ge ? DET_W'(rem2 - {1'b0, r_ad}) : DET_W'(rem2);
            r_dq  <= {r_dq[QW-2:0], ge};
        end
    end

    assign lim    = r_neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign mag    = (r_ovf || (r_dq > lim)) ? lim : r_dq;
    assign o_quo  = r_neg ? -mag : mag;
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: design/triangle_tangent_frame.sv
// Triangle tangent frame: corners in, one tangent/bitangent item per triangle out.
// Depends on ttf_pkg, ttf_mul and ttf_div.
//
// Corners arrive on the slave stream, three to a triangle in list order. The first two
// are stored as they are accepted. The third starts the sequencer: fourteen products
// on the shared multiplier, each through ST_MUL and ST_ACC, and six divisions on the
// bit-serial divider, each started in ST_DIV_GO and awaited in ST_DIV_WAIT, each
// division following its two products; the result item is valid after the last one.
// The result item carries tangent x, y, z then bitangent x, y, z in tdata and the
// degenerate flag in tuser; a zero UV determinant gives zero vectors with the flag set,
// once the determinant is found and with no division.
// The result waits in an output register; the first two corners of the next triangle
// are still taken while the receiver stalls, the third waits until the result has gone.
// Reset (synchronous, active low) drops a partly received triangle and any pending result.
`default_nettype none
module triangle_tangent_frame #(
    parameter int UV_FRAC_BITS = ttf_pkg::UV_FRAC_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], tex_u[111:96], tex_v[127:112]
    input  wire logic [127:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z, 32 bits each
    output logic [191:0]      o_m_tdata,
    // degenerate
    output logic [0:0]        o_m_tuser
);
    import ttf_pkg::*;

    t_state r_state, n_state;
    logic [1:0]        r_count, n_count;
    logic [TERM_W-1:0] r_t, n_t;
    logic              r_ovalid, n_ovalid;
    logic              r_deg;

    logic signed [POS_W-1:0] r_hp1 [3];
    logic signed [POS_W-1:0] r_hp2 [3];
    logic signed [POS_W-1:0] r_p3  [3];
    logic signed [UV_W-1:0]  r_u1, r_v1, r_u2, r_v2, r_u3, r_v3;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [DET_W-1:0] r_det;
    logic signed [POS_W-1:0] r_res [NUM_COMP];

    logic signed [POS_W-1:0]  in_pos [3];
    logic signed [DUV_W-1:0]  du1, dv1, du2, dv2;
    logic signed [EDGE_W-1:0] e1 [3];
    logic signed [EDGE_W-1:0] e2 [3];
    logic [2:0]               comp;
    logic [1:0]               axis;
    logic signed [EDGE_W-1:0] ea, eb;
    logic signed [DUV_W-1:0]  mul_a;
    logic signed [EDGE_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     div_start, div_done;
    logic signed [POS_W-1:0]  quo;
    logic                     wr_corner, set_degen, wr_res;

    assign in_pos[0] = i_s_tdata[31:0];
    assign in_pos[1] = i_s_tdata[63:32];
    assign in_pos[2] = i_s_tdata[95:64];

    assign du1 = DUV_W'(r_u2) - DUV_W'(r_u1);
    assign dv1 = DUV_W'(r_v2) - DUV_W'(r_v1);
    assign du2 = DUV_W'(r_u3) - DUV_W'(r_u2);
    assign dv2 = DUV_W'(r_v3) - DUV_W'(r_v2);

    for (genvar g = 0; g < 3; g++) begin : g_edge
        assign e1[g] = EDGE_W'(r_hp2[g]) - EDGE_W'(r_hp1[g]);
        assign e2[g] = EDGE_W'(r_p3[g]) - EDGE_W'(r_hp2[g]);
    end

    // Terms come in pairs: the even one loads the accumulator, the odd one subtracts.
    assign comp = 3'(r_t[TERM_W-1:1]) - 3'd1;
    assign axis = (comp < 3'd3) ? comp[1:0] : 2'(comp - 3'd3);

    always_comb begin
        case (axis)
            2'd0:    begin ea = e1[0]; eb = e2[0]; end
            2'd1:    begin ea = e1[1]; eb = e2[1]; end
            default: begin ea = e1[2]; eb = e2[2]; end
        endcase
        if (r_t < TERM_FIRST_COMP) begin
            mul_a = r_t[0] ? du2 : du1;
            mul_b = r_t[0] ? EDGE_W'(dv1) : EDGE_W'(dv2);
        end else if (comp < 3'd3) begin
            mul_a = r_t[0] ? dv1 : dv2;
            mul_b = r_t[0] ? eb : ea;
        end else begin
            mul_a = r_t[0] ? du2 : du1;
            mul_b = r_t[0] ? ea : eb;
        end
    end

    ttf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign n_acc = r_t[0] ? (r_acc - ACC_W'(prod)) : ACC_W'(prod);

    ttf_div #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_t      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_t      <= n_t;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_t        = r_t;
        n_ovalid   = r_ovalid && !i_m_tready;
        o_s_tready = 1'b0;
        div_start  = 1'b0;
        wr_corner  = 1'b0;
        set_degen  = 1'b0;
        wr_res     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = !(r_count[1] && r_ovalid);
                if (i_s_tvalid && o_s_tready) begin
                    wr_corner = 1'b1;
                    if (!r_count[1]) begin
                        n_count = r_count + 2'd1;
                    end else begin
                        n_count = '0;
                        n_t     = '0;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_t == TERM_DET_LAST) begin
                    if (n_acc[DET_W-1:0] == '0) begin
                        set_degen = 1'b1;
                        n_ovalid  = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_t     = TERM_FIRST_COMP;
                        n_state = ST_MUL;
                    end
                end else if (!r_t[0]) begin
                    n_t     = r_t + TERM_W'(1);
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    wr_res = 1'b1;
                    if (r_t == TERM_LAST) begin
                        n_ovalid = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_t     = r_t + TERM_W'(1);
                        n_state = ST_MUL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_corner) begin
            for (int k = 0; k < 3; k++) begin
                if (r_count == 2'd0) begin
                    r_hp1[k] <= in_pos[k];
                end else if (r_count == 2'd1) begin
                    r_hp2[k] <= in_pos[k];
                end else begin
                    r_p3[k] <= in_pos[k];
                end
            end
            if (r_count == 2'd0) begin
                r_u1 <= i_s_tdata[111:96];
                r_v1 <= i_s_tdata[127:112];
            end else if (r_count == 2'd1) begin
                r_u2 <= i_s_tdata[111:96];
                r_v2 <= i_s_tdata[127:112];
            end else begin
                r_u3 <= i_s_tdata[111:96];
                r_v3 <= i_s_tdata[127:112];
            end
        end
        if (r_state == ST_ACC) begin
            r_acc <= n_acc;
            if (r_t == TERM_DET_LAST) begin
                r_det <= n_acc[DET_W-1:0];
            end
        end
        if (set_degen) begin
            r_deg <= 1'b1;
            for (int k = 0; k < NUM_COMP; k++) begin
                r_res[k] <= '0;
            end
        end else if (wr_res) begin
            r_deg <= 1'b0;
            for (int k = 0; k < NUM_COMP; k++) begin
                if (comp == 3'(k)) begin
                    r_res[k] <= quo;
                end
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_res[5], r_res[4], r_res[3], r_res[2], r_res[1], r_res[0]};
    assign o_m_tuser  = r_deg;
endmodule
`default_nettype wire

FILE: dv/triangle_tangent_frame_tb.sv
// Testbench for triangle_tangent_frame: streams triangle corners in and checks each
// tangent/bitangent item against an in-bench fixed-point predictor. Depends on ttf_pkg.
`default_nettype none
module triangle_tangent_frame_tb;
    import ttf_pkg::*;

    localparam int UVF = UV_FRAC_DEF;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
        logic signed [15:0] tu;
        logic signed [15:0] tv;
    } t_corner;

    typedef struct {
        logic [31:0] comp [6];
        logic        degenerate;
    } t_frame;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [127:0] i_s_tdata = '0;
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [191:0] o_m_tdata;
    logic [0:0]   o_m_tuser;

    t_frame frames_due [$];
    t_corner held_a, held_b;
    int corners_held = 0;
    int errors = 0;
    int idle_cycles = 0;
    bit rx_gaps = 1'b0;
    bit tx_gaps = 1'b0;
    bit rx_hold = 1'b0;

    triangle_tangent_frame u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // (num * 2^UVF) / det, truncated toward zero and saturated to 32 bits.
    function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
                                                    logic signed [127:0] det);
        logic signed [127:0] q;
        q = (num <<< UVF) / det;
        if (q > 128'sd2147483647) q = 128'sd2147483647;
        if (q < -128'sd2147483648) q = -128'sd2147483648;
        return q[31:0];
    endfunction

    function automatic t_frame predict_frame(t_corner c1, t_corner c2, t_corner c3);
        t_frame f;
        logic signed [127:0] du1, du2, dv1, dv2, det, e1, e2;
        logic signed [127:0] p1 [3], p2 [3], p3 [3];
        p1 = '{c1.px, c1.py, c1.pz};
        p2 = '{c2.px, c2.py, c2.pz};
        p3 = '{c3.px, c3.py, c3.pz};
        du1 = 128'(c2.tu) - 128'(c1.tu);
        dv1 = 128'(c2.tv) - 128'(c1.tv);
        du2 = 128'(c3.tu) - 128'(c2.tu);
        dv2 = 128'(c3.tv) - 128'(c2.tv);
        det = du1 * dv2 - du2 * dv1;
        f.degenerate = (det == 0);
        for (int i = 0; i < 3; i++) begin
            e1 = p2[i] - p1[i];
            e2 = p3[i] - p2[i];
            if (det == 0) begin
                f.comp[i] = '0;
                f.comp[3 + i] = '0;
            end else begin
                f.comp[i] = scaled_quotient(dv2 * e1 - dv1 * e2, det);
                f.comp[3 + i] = scaled_quotient(du1 * e2 - du2 * e1, det);
            end
        end
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Sends one corner and updates the expected frames once it is accepted.
    // The valid line stays high afterwards until the next corner or a gap replaces it.
    task automatic send_corner(t_corner c);
        while (tx_gaps && $urandom_range(99) < 9) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {c.tv, c.tu, c.pz, c.py, c.px};
        do @(posedge i_clk); while (!o_s_tready);
        if (corners_held == 0) begin
            held_a = c;
            corners_held = 1;
        end else if (corners_held == 1) begin
            held_b = c;
            corners_held = 2;
        end else begin
            frames_due.push_back(predict_frame(held_a, held_b, c));
            corners_held = 0;
        end
    endtask

    function automatic t_corner random_corner(int mode);
        t_corner c;
        c.px = $urandom; c.py = $urandom; c.pz = $urandom;
        c.tu = 16'($urandom); c.tv = 16'($urandom);
        if (mode == 1) begin
            // Modest positions and well-spread UVs keep results in range.
            c.px = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            c.py = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            c.pz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        end else if (mode == 2) begin
            c.tu = 16'($signed($urandom_range(0, 8)) - 4);
            c.tv = 16'($signed($urandom_range(0, 8)) - 4);
        end
        return c;
    endfunction

    task automatic send_triangle(t_corner a, t_corner b, t_corner c);
        send_corner(a);
        send_corner(b);
        send_corner(c);
    endtask

    task automatic test_directed();
        t_corner z, a, b, c;
        z = '0;
        // Unit right triangle in UV space.
        a = z; b = z; c = z;
        b.px = 32'sh0001_0000; b.tu = 16'sh4000;
        c.px = 32'sh0001_0000; c.py = 32'sh0001_0000; c.tu = 16'sh4000; c.tv = 16'sh4000;
        send_triangle(a, b, c);
        // Zero determinant: the last two corners share a UV.
        send_triangle(z, b, b);
        // Extreme positions with a tiny UV span force saturation both ways.
        a = z; b = z; c = z;
        a.px = 32'h8000_0000; a.py = 32'h7fff_ffff; a.pz = 32'h8000_0000;
        b.px = 32'h7fff_ffff; b.py = 32'h8000_0000; b.pz = 32'h7fff_ffff; b.tu = 16'sd1;
        c.px = 32'h8000_0000; c.py = 32'h7fff_ffff; c.tu = 16'sd1; c.tv = 16'sd1;
        send_triangle(a, b, c);
        // Extreme texture coordinates.
        a = z; b = z; c = z;
        a.tu = 16'h8000; a.tv = 16'h7fff; a.px = 32'hffff_ffff;
        b.tu = 16'h7fff; b.tv = 16'h8000; b.py = 32'hffff_ffff;
        c.tu = 16'h8000; c.tv = 16'h8000; c.pz = 32'hffff_ffff;
        send_triangle(a, b, c);
        // Collinear UVs give a zero determinant with non-zero deltas.
        a = z; b = z; c = z;
        b.tu = 16'sd100; b.tv = 16'sd100; c.tu = 16'sd300; c.tv = 16'sd300;
        c.pz = 32'sh0003_0000;
        send_triangle(a, b, c);
        send_triangle(random_corner(0), random_corner(0), random_corner(0));
    endtask

    task automatic test_random(int triangles);
        int mode;
        for (int t = 0; t < triangles; t++) begin
            mode = $urandom_range(2);
            send_triangle(random_corner(mode), random_corner(mode), random_corner(mode));
        end
    endtask

    // The receiver stops for a long stretch while corners keep coming.
    task automatic test_back_pressure();
        rx_hold = 1'b1;
        fork
            test_random(4);
            begin
                repeat (1500) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= !rx_hold && !(rx_gaps && $urandom_range(99) < 9);
    end

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected result item", o_m_tdata[31:0], 32'd0);
            end else begin
                want = frames_due.pop_front();
                for (int i = 0; i < 6; i++)
                    if (o_m_tdata[32*i +: 32] !== want.comp[i])
                        report_mismatch($sformatf("component %0d", i),
                                        o_m_tdata[32*i +: 32], want.comp[i]);
                if (o_m_tuser[0] !== want.degenerate)
                    report_mismatch("degenerate", 32'(o_m_tuser), 32'(want.degenerate));
            end
        end
    end

    // Watchdog over cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(40);
        rx_gaps = 1'b1;
        tx_gaps = 1'b1;
        test_random(80);
        test_back_pressure();
        test_random(90);
        i_s_tvalid <= 1'b0;
        waited = 0;
        while (frames_due.size() != 0 && waited < WATCH_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);
        if (errors == 0 && frames_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/ttf_pkg.sv
design/ttf_mul.sv
design/ttf_div.sv
design/triangle_tangent_frame.sv
dv/triangle_tangent_frame_tb.sv
